// ===== hdl/ncr_pkg.sv =====
// Shared types, command codes and constants of the node command responder.
package ncr_pkg;

	localparam logic [7:0] FRAME_START = 8'hAA;
	localparam logic [7:0] FRAME_END   = 8'h55;

	localparam logic [7:0] OP_SET_MODE   = 8'h01;
	localparam logic [7:0] OP_STATUS_REQ = 8'h02;
	localparam logic [7:0] OP_SET_ALERT  = 8'h03;
	localparam logic [7:0] OP_BUZZ_ON    = 8'h05;
	localparam logic [7:0] OP_BUZZ_OFF   = 8'h06;
	localparam logic [7:0] OP_STATUS_RPT = 8'h10;
	localparam logic [7:0] OP_MODE_ACK   = 8'h12;
	localparam logic [7:0] OP_HEARTBEAT  = 8'h13;

	localparam logic [7:0] MODE_LOCAL     = 8'd2;
	localparam logic [7:0] ALERT_HIGH_LVL = 8'd3;

	localparam logic        ACTION_PACKET = 1'b0;
	localparam logic        ACTION_TICK   = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

	// Payload lengths carried by reply frames
	localparam logic [2:0]  LEN_ONE  = 3'd1;
	localparam logic [2:0]  LEN_FOUR = 3'd4;

	// Last byte position of the longest frame
	localparam logic [3:0]  MAX_BYTE_IDX = 4'd8;

	localparam int unsigned NCR_QUEUE_DEPTH = 4;

	typedef struct packed {
		logic        action;
		logic [7:0]  command;
		logic [7:0]  length;
		logic [7:0]  first_data;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       byte_valid;
		logic       last;
		logic [7:0] mode;
		logic [7:0] alert;
		logic       buzzer;
		logic       connected;
	} out_item_t;

	typedef struct packed {
		logic [7:0] mode;
		logic [7:0] alert;
		logic       buzzer;
		logic       connected;
	} node_status_t;

	// One reply job handed from the classifier to the serializer
	typedef struct packed {
		logic            has_frame;
		logic [7:0]      op;
		logic [2:0]      n;
		logic [3:0][7:0] data;
		logic [7:0]      crc;
		node_status_t    status;
	} frame_desc_t;

endpackage

// ===== hdl/ncr_front.sv =====
// Command classifier: accepts items, updates node state, builds reply jobs.
module ncr_front import ncr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	input  logic        queue_full,
	output logic        push,
	output frame_desc_t push_desc
);

	logic [7:0]  mode_q, mode_d;
	logic [7:0]  alert_q, alert_d;
	logic        buzzer_q, buzzer_d;
	logic [15:0] uptime_q, uptime_d;
	logic [31:0] last_pkt_q, last_pkt_d;
	logic        alive_q, alive_d;
	logic [15:0] timeout_q;
	logic [31:0] elapsed;
	logic        timed_out;
	frame_desc_t desc;

	function automatic logic follow_alert(input logic [7:0] lvl, input logic cur);
		logic res;
		res = cur;
		if (lvl <= 8'd1)
			res = 1'b0;
		else if (lvl inside {8'd3, 8'd4})
			res = 1'b1;
		return res;
	endfunction

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	assign elapsed   = in_data.now_ms - last_pkt_q;
	assign timed_out = elapsed > {16'd0, timeout_q};

	always_comb begin
		mode_d     = mode_q;
		alert_d    = alert_q;
		buzzer_d   = buzzer_q;
		uptime_d   = uptime_q;
		last_pkt_d = last_pkt_q;
		alive_d    = alive_q;
		desc       = '0;
		if (in_data.action == ACTION_PACKET) begin
			last_pkt_d = in_data.now_ms;
			case (in_data.command)
				OP_SET_MODE: begin
					if (in_data.length != 8'd0) begin
						mode_d         = in_data.first_data;
						desc.has_frame = 1'b1;
						desc.op        = OP_MODE_ACK;
						desc.n         = LEN_ONE;
						desc.data[0]   = in_data.first_data;
					end
				end
				OP_STATUS_REQ: begin
					desc.has_frame = 1'b1;
					desc.op        = OP_STATUS_RPT;
					desc.n         = LEN_FOUR;
					desc.data[0]   = mode_q;
					desc.data[1]   = alert_q;
					desc.data[2]   = uptime_q[7:0];
					desc.data[3]   = uptime_q[15:8];
				end
				OP_SET_ALERT: begin
					if (in_data.length != 8'd0) begin
						alert_d  = in_data.first_data;
						buzzer_d = follow_alert(in_data.first_data, buzzer_q);
					end
				end
				OP_BUZZ_ON:  buzzer_d = 1'b1;
				OP_BUZZ_OFF: buzzer_d = 1'b0;
				default: ;
			endcase
		end else begin
			uptime_d       = uptime_q + 16'd1;
			desc.has_frame = 1'b1;
			desc.op        = OP_HEARTBEAT;
			desc.n         = LEN_ONE;
			desc.data[0]   = mode_q;
			if (timed_out) begin
				alive_d = 1'b0;
				// Fall back to local autonomy once; leave alert alone if already local
				if (mode_q != MODE_LOCAL) begin
					mode_d   = MODE_LOCAL;
					alert_d  = ALERT_HIGH_LVL;
					buzzer_d = follow_alert(ALERT_HIGH_LVL, buzzer_q);
				end
			end else begin
				alive_d = 1'b1;
			end
		end
		desc.crc = desc.op ^ {5'd0, desc.n} ^ desc.data[0] ^ desc.data[1]
			^ desc.data[2] ^ desc.data[3];
		desc.status.mode      = mode_d;
		desc.status.alert     = alert_d;
		desc.status.buzzer    = buzzer_d;
		desc.status.connected = alive_d;
	end

	assign push_desc = desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			alert_q    <= '0;
			buzzer_q   <= 1'b0;
			uptime_q   <= '0;
			last_pkt_q <= '0;
			alive_q    <= 1'b0;
			timeout_q  <= TIMEOUT_RESET;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_data;
			if (push) begin
				mode_q     <= mode_d;
				alert_q    <= alert_d;
				buzzer_q   <= buzzer_d;
				uptime_q   <= uptime_d;
				last_pkt_q <= last_pkt_d;
				alive_q    <= alive_d;
			end
		end
	end

	a_uptime_tick: assert property (@(posedge clk) disable iff (!arst_n)
		push && in_data.action == ACTION_TICK |=> uptime_q == $past(uptime_q) + 16'd1)
		else $error("uptime did not advance on tick");

	a_uptime_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(uptime_q) && $stable(mode_q) && $stable(alert_q))
		else $error("node state changed without a transfer");

	a_timeout_local: assert property (@(posedge clk) disable iff (!arst_n)
		push && in_data.action == ACTION_TICK && timed_out
		|=> mode_q == MODE_LOCAL && !alive_q)
		else $error("timeout did not force local mode");

endmodule

// ===== hdl/ncr_queue.sv =====
// Short job queue between the classifier and the frame serializer.
module ncr_queue import ncr_pkg::*; #(
	parameter int unsigned DEPTH = NCR_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_desc_t push_desc,
	output logic        full,
	input  logic        pop,
	output frame_desc_t head,
	output logic        head_valid
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	frame_desc_t    slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr);
		logic [PW-1:0] res;
		if (ptr == PW'(DEPTH - 1))
			res = '0;
		else
			res = ptr + PW'(1);
		return res;
	endfunction

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= advance(wr_ptr_q);
			if (pop)
				rd_ptr_q <= advance(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

// ===== hdl/ncr_back.sv =====
// Frame serializer: walks each reply job and emits one byte per transfer, or one status-only result.
module ncr_back import ncr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_desc_t head,
	input  logic        head_valid,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	logic [3:0] idx_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic [3:0] n_ext, crc_idx, end_idx, data_off;
	logic [7:0] byte_sel;
	logic       last_byte;
	logic       load;

	assign n_ext    = {1'b0, head.n};
	assign crc_idx  = n_ext + 4'd3;
	assign end_idx  = n_ext + 4'd4;
	assign data_off = idx_q - 4'd3;

	always_comb begin
		if (idx_q == 4'd0)
			byte_sel = FRAME_START;
		else if (idx_q == 4'd1)
			byte_sel = head.op;
		else if (idx_q == 4'd2)
			byte_sel = {5'd0, head.n};
		else if (idx_q == crc_idx)
			byte_sel = head.crc;
		else if (idx_q == end_idx)
			byte_sel = FRAME_END;
		else
			byte_sel = head.data[data_off[1:0]];
	end

	assign last_byte = head.has_frame ? (idx_q == end_idx) : 1'b1;
	// Refill the output register whenever a job is at the head and the register is empty or being drained
	assign load      = head_valid && (!out_valid_q || out_ready);
	assign pop       = load && last_byte;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.frame_byte <= head.has_frame ? byte_sel : 8'd0;
			out_q.byte_valid <= head.has_frame;
			out_q.last       <= last_byte;
			out_q.mode       <= head.status.mode;
			out_q.alert      <= head.status.alert;
			out_q.buzzer     <= head.status.buzzer;
			out_q.connected  <= head.status.connected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				idx_q <= last_byte ? 4'd0 : idx_q + 4'd1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= MAX_BYTE_IDX)
		else $error("byte index past end of longest frame");

	a_mid_frame_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 4'd0 |-> head_valid && head.has_frame)
		else $error("frame in progress without a job at the head");

	a_status_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.byte_valid |-> out_q.last && out_q.frame_byte == 8'd0)
		else $error("status-only result not marked last");

	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.byte_valid && out_q.last |-> out_q.frame_byte == FRAME_END)
		else $error("frame did not close with end byte");

endmodule

// ===== hdl/node_command_responder_core.sv =====
// Node command responder top level: classifier, job queue and frame serializer.
//
// Usage: the input channel (in_valid/in_ready/in_data) carries one decoded host
// packet or one-second tick per transfer. The output channel (out_valid/
// out_ready/out_data) carries one frame byte per transfer, or a single
// status-only result (byte_valid low) for commands that send no reply.
// Every result carries the node status after its item, and last marks the
// final result of that item. cfg_we writes cfg_data into the link timeout.
// The first result of an item is registered in the job queue and then in the
// output register. The serializer emits one byte per cycle while out_ready is
// high, so an item yields 9 results (status report), 6 (ack or heartbeat) or 1
// (no frame) at the output port; the classifier takes one item per cycle
// until the QUEUE_DEPTH job queue fills. Reset clears the node state, loads a
// link timeout of 5000 ms and empties the queue and output register. When
// the receiver stalls, the current byte holds in the output register, the
// queue fills, and in_ready drops once it is full.
module node_command_responder_core import ncr_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = NCR_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	logic        push, pop, queue_full, head_valid;
	frame_desc_t push_desc, head;

	ncr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.queue_full (queue_full),
		.push       (push),
		.push_desc  (push_desc)
	);

	ncr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.full       (queue_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	ncr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
